// ===== rtl/core/cts_pkg.sv =====
`default_nettype none
package cts_pkg;

  // Fixed field widths of the payload.
  localparam int ID_W      = 24;
  localparam int CRD_W     = 32;
  localparam int CFG_W     = 24;
  localparam int DEPTH_W   = 2;
  localparam int MAX_DEPTH_DEF = 3;

  // Centroid sum width: three coordinates, a rounding one and a bias.
  localparam int SUM_W     = CRD_W + 2;
  // Bits of the sum resolved per cycle by the divide-by-three unit.
  localparam int DIV_STEP  = 8;
  localparam int DIV_NSTEP = (SUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_PW    = DIV_NSTEP * DIV_STEP;
  localparam int DIV_CW    = $clog2(DIV_NSTEP + 1);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_DEPTH       = 1'b0,
    REG_POINT_COUNT = 1'b1
  } cts_reg_t;

  // Result kinds.
  typedef enum logic {
    KIND_POINT = 1'b0,
    KIND_TRI   = 1'b1
  } cts_kind_t;

  typedef struct packed {
    logic        [ID_W-1:0]  vertex_a_id;
    logic        [ID_W-1:0]  vertex_b_id;
    logic        [ID_W-1:0]  vertex_c_id;
    logic signed [CRD_W-1:0] vertex_a_x;
    logic signed [CRD_W-1:0] vertex_a_y;
    logic signed [CRD_W-1:0] vertex_a_z;
    logic signed [CRD_W-1:0] vertex_b_x;
    logic signed [CRD_W-1:0] vertex_b_y;
    logic signed [CRD_W-1:0] vertex_b_z;
    logic signed [CRD_W-1:0] vertex_c_x;
    logic signed [CRD_W-1:0] vertex_c_y;
    logic signed [CRD_W-1:0] vertex_c_z;
  } cts_in_t;

  typedef struct packed {
    logic                    result_kind;
    logic        [ID_W-1:0]  first_id;
    logic        [ID_W-1:0]  second_id;
    logic        [ID_W-1:0]  third_id;
    logic signed [CRD_W-1:0] point_x;
    logic signed [CRD_W-1:0] point_y;
    logic signed [CRD_W-1:0] point_z;
    logic                    last_of_run;
  } cts_out_t;

  // One working vertex.
  typedef struct packed {
    logic        [ID_W-1:0]  id;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
  } cts_vtx_t;

  typedef cts_vtx_t [2:0] cts_tri_t;

  // Vertices of child k of triangle p split at centroid m.
  function automatic cts_tri_t cts_child(input logic [1:0] k, input cts_tri_t p,
                                         input cts_vtx_t m);
    cts_tri_t t;
    case (k)
      2'd0: begin
        t[0] = p[0]; t[1] = m;    t[2] = p[1];
      end
      2'd1: begin
        t[0] = p[1]; t[1] = p[2]; t[2] = m;
      end
      default: begin
        t[0] = p[2]; t[1] = p[0]; t[2] = m;
      end
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cts_front.sv =====
`default_nettype none
module cts_front
  import cts_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF,
  parameter int LV_W      = $clog2(MAX_DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               depth_we,
  input  wire logic [DEPTH_W-1:0] depth_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cts_in_t            in_data,
  output logic                    job_valid,
  input  wire logic               job_ready,
  output cts_in_t                 job_tri,
  output logic [LV_W-1:0]         job_depth
);

  logic [DEPTH_W-1:0] depth_r;
  cts_in_t            tri_mem_r   [2];
  logic [LV_W-1:0]    depth_mem_r [2];
  logic               wp_r, rp_r;
  logic [1:0]         cnt_r;
  logic [LV_W-1:0]    depth_sat;
  logic               push, pop;

  // Depth is clamped to what the back end supports as the item is queued.
  always_comb begin
    if (int'(depth_r) > MAX_DEPTH) depth_sat = LV_W'(MAX_DEPTH);
    else                           depth_sat = LV_W'(depth_r);
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;
  assign job_tri   = tri_mem_r[rp_r];
  assign job_depth = depth_mem_r[rp_r];

  // Two-entry queue toward the traversal engine.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= DEPTH_W'(1);
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      cnt_r   <= 2'd0;
    end else begin
      if (depth_we) depth_r <= depth_wdata;
      if (push) begin
        tri_mem_r[wp_r]   <= in_data;
        depth_mem_r[wp_r] <= depth_sat;
        wp_r              <= ~wp_r;
      end
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cts_div3.sv =====
`default_nettype none
module cts_div3
  import cts_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] sum,
  output logic                  busy,
  output logic signed [CRD_W-1:0] coord
);

  logic [DIV_PW-1:0] sh_r, sh_nxt;
  logic [DIV_PW-1:0] q_r, q_nxt;
  logic [1:0]        rem_r, rem_nxt;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;

  // Restoring division by three, DIV_STEP quotient bits per cycle.
  always_comb begin
    logic [2:0] r3;
    sh_nxt  = sh_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    for (int i = 0; i < DIV_STEP; i++) begin
      r3     = {rem_nxt, sh_nxt[DIV_PW-1]};
      sh_nxt = {sh_nxt[DIV_PW-2:0], 1'b0};
      if (r3 >= 3'd3) begin
        rem_nxt = 2'(r3 - 3'd3);
        q_nxt   = {q_nxt[DIV_PW-2:0], 1'b1};
      end else begin
        rem_nxt = r3[1:0];
        q_nxt   = {q_nxt[DIV_PW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CW'(DIV_NSTEP);
      sh_r   <= DIV_PW'(sum);
      q_r    <= '0;
      rem_r  <= 2'd0;
    end else if (busy_r) begin
      sh_r  <= sh_nxt;
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - DIV_CW'(1);
      if (cnt_r == DIV_CW'(1)) busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  // The sum carries a bias of three halves of the range; the quotient keeps half the range, undone here.
  assign coord = {~q_r[CRD_W-1], q_r[CRD_W-2:0]};

endmodule
`default_nettype wire

// ===== rtl/core/cts_back.sv =====
`default_nettype none
module cts_back
  import cts_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF,
  parameter int LV_W      = $clog2(MAX_DEPTH + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            id_we,
  input  wire logic [ID_W-1:0] id_wdata,
  input  wire logic            job_valid,
  output logic                 job_ready,
  input  wire cts_in_t         job_tri,
  input  wire logic [LV_W-1:0] job_depth,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output cts_out_t             out_data
);

  typedef enum logic [1:0] {S_IDLE, S_VISIT, S_DIV, S_RET} state_t;

  localparam logic [SUM_W-1:0] BIAS = SUM_W'(3) << (CRD_W - 1);

  state_t           state_r;
  logic [LV_W-1:0]  lv_r, depth_r, lv_inc, lv_dec;
  cts_tri_t         frame_r [MAX_DEPTH+1];
  cts_vtx_t         mid_r   [MAX_DEPTH+1];
  logic [1:0]       kidx_r  [MAX_DEPTH+1];
  logic [ID_W-1:0]  next_id_r;
  logic             out_valid_r;
  cts_out_t         out_data_r;

  cts_tri_t         cur, par;
  cts_vtx_t         cen;
  logic [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic             can_emit, emit_now, leaf, last, div_start, div_busy;
  logic signed [CRD_W-1:0] cx, cy, cz;

  assign lv_inc    = lv_r + LV_W'(1);
  assign lv_dec    = lv_r - LV_W'(1);
  assign cur       = frame_r[lv_r];
  assign par       = frame_r[lv_dec];
  assign can_emit  = !out_valid_r || out_ready;
  assign leaf      = (lv_r == depth_r);
  assign job_ready = (state_r == S_IDLE);
  assign div_start = (state_r == S_VISIT) && !leaf;

  // A result register is loaded on a leaf visit or a finished centroid.
  assign emit_now  = can_emit && (((state_r == S_VISIT) && leaf) ||
                                  ((state_r == S_DIV) && !div_busy));

  // Biased centroid sums; always positive so the divider stays unsigned.
  assign sum_x = SUM_W'(cur[0].x) + SUM_W'(cur[1].x) + SUM_W'(cur[2].x) + BIAS
               + SUM_W'(1);
  assign sum_y = SUM_W'(cur[0].y) + SUM_W'(cur[1].y) + SUM_W'(cur[2].y) + BIAS
               + SUM_W'(1);
  assign sum_z = SUM_W'(cur[0].z) + SUM_W'(cur[1].z) + SUM_W'(cur[2].z) + BIAS
               + SUM_W'(1);

  cts_div3 u_div_x (.clk, .rst_n, .start(div_start), .sum(sum_x), .busy(div_busy),
                    .coord(cx));
  cts_div3 u_div_y (.clk, .rst_n, .start(div_start), .sum(sum_y), .busy(),
                    .coord(cy));
  cts_div3 u_div_z (.clk, .rst_n, .start(div_start), .sum(sum_z), .busy(),
                    .coord(cz));

  assign cen = '{id: next_id_r, x: cx, y: cy, z: cz};

  // A leaf is the last one when every level above it is on its final child.
  always_comb begin
    last = 1'b1;
    for (int j = 0; j <= MAX_DEPTH; j++) begin
      if (j < int'(lv_r) && kidx_r[j] != 2'd2) last = 1'b0;
    end
  end

  // Depth-first traversal with one frame per level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lv_r        <= '0;
      depth_r     <= '0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j <= MAX_DEPTH; j++) kidx_r[j] <= 2'd0;
    end else begin
      if (emit_now) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (id_we) next_id_r <= id_wdata;
      case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            frame_r[0] <= '{
              '{id: job_tri.vertex_c_id, x: job_tri.vertex_c_x,
                y: job_tri.vertex_c_y, z: job_tri.vertex_c_z},
              '{id: job_tri.vertex_b_id, x: job_tri.vertex_b_x,
                y: job_tri.vertex_b_y, z: job_tri.vertex_b_z},
              '{id: job_tri.vertex_a_id, x: job_tri.vertex_a_x,
                y: job_tri.vertex_a_y, z: job_tri.vertex_a_z}};
            depth_r <= job_depth;
            lv_r    <= '0;
            state_r <= S_VISIT;
          end
        end
        S_VISIT: begin
          if (!leaf) begin
            state_r <= S_DIV;
          end else if (can_emit) begin
            out_data_r  <= '{result_kind: KIND_TRI, first_id: cur[0].id,
                             second_id: cur[1].id, third_id: cur[2].id,
                             point_x: '0, point_y: '0, point_z: '0,
                             last_of_run: last};
            state_r <= S_RET;
          end
        end
        S_DIV: begin
          if (!div_busy && can_emit) begin
            out_data_r  <= '{result_kind: KIND_POINT, first_id: next_id_r,
                             second_id: '0, third_id: '0,
                             point_x: cx, point_y: cy, point_z: cz,
                             last_of_run: 1'b0};
            if (next_id_r != '1) next_id_r <= next_id_r + ID_W'(1);
            mid_r[lv_r]    <= cen;
            kidx_r[lv_r]   <= 2'd0;
            frame_r[lv_inc] <= cts_child(2'd0, cur, cen);
            lv_r           <= lv_inc;
            state_r        <= S_VISIT;
          end
        end
        S_RET: begin
          if (lv_r == '0) begin
            state_r <= S_IDLE;
          end else if (kidx_r[lv_dec] == 2'd2) begin
            lv_r <= lv_dec;
          end else begin
            kidx_r[lv_dec] <= kidx_r[lv_dec] + 2'd1;
            frame_r[lv_r]  <= cts_child(kidx_r[lv_dec] + 2'd1, par, mid_r[lv_dec]);
            state_r        <= S_VISIT;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/core/centroid_triangle_subdivider.sv =====
// Flow: an item waits in the input queue; the traversal then visits and returns from each
// leaf triangle, takes each centroid point through a start step, the divide-by-three steps
// at eight sum bits each and an issue step, and passes through a return step for each
// parent level it goes back to; output back-pressure can hold a leaf visit or an issue.
// Throughput is one triangle at a time, with a two-entry queue taking items meanwhile.
// Synchronous active-low reset clears control state, sets depth one and id counter zero.
`default_nettype none
module centroid_triangle_subdivider
  import cts_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire cts_in_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output cts_out_t              out_data
);

  localparam int LV_W = $clog2(MAX_DEPTH + 1);

  logic            job_valid, job_ready;
  cts_in_t         job_tri;
  logic [LV_W-1:0] job_depth;
  logic            depth_we, id_we;

  // Register decode.
  assign depth_we = cfg_we && (cfg_index == REG_DEPTH);
  assign id_we    = cfg_we && (cfg_index == REG_POINT_COUNT);

  cts_front #(.MAX_DEPTH(MAX_DEPTH), .LV_W(LV_W)) u_front (
    .clk, .rst_n,
    .depth_we, .depth_wdata(cfg_wdata[DEPTH_W-1:0]),
    .in_valid, .in_ready, .in_data,
    .job_valid, .job_ready, .job_tri, .job_depth
  );

  cts_back #(.MAX_DEPTH(MAX_DEPTH), .LV_W(LV_W)) u_back (
    .clk, .rst_n,
    .id_we, .id_wdata(cfg_wdata[ID_W-1:0]),
    .job_valid, .job_ready, .job_tri, .job_depth,
    .out_valid, .out_ready, .out_data
  );

endmodule
`default_nettype wire
